[src/assert_macros.svh]
// Assertion macros shared by the keyer envelope RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ICWK_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ICWK_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[src/icwk_pkg.sv]
// Shared types and constants for the iambic CW keyer envelope block.
package icwk_pkg;

   // Field and register widths.
   localparam int AMP_BITS       = 16;
   localparam int WPM_BITS       = 7;
   localparam int RATIO_BITS     = 11;
   localparam int STEP_BITS      = 16;
   localparam int DELAY_BITS     = 12;
   localparam int DOT_BITS       = 11;
   localparam int LEN_BITS       = 14;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Timing constants.
   localparam int DOT_MS_NUMERATOR  = 1200;
   localparam int TIME_BITS_DEFAULT = 16;

   // Register reset values.
   localparam logic                  KEYER_ENABLE_RESET  = 1'b1;
   localparam logic                  IAMBIC_ENABLE_RESET = 1'b0;
   localparam int                    WPM_RESET           = 20;
   localparam logic [RATIO_BITS-1:0] RATIO_RESET         = 11'd768;
   localparam logic [STEP_BITS-1:0]  EDGE_STEP_RESET     = 16'd655;
   localparam logic [DELAY_BITS-1:0] START_DELAY_RESET   = 12'd0;
   localparam logic [DOT_BITS-1:0]   DOT_LEN_RESET       =
      DOT_BITS'(DOT_MS_NUMERATOR / WPM_RESET);
   localparam logic [LEN_BITS-1:0]   DASH_LEN_RESET      =
      LEN_BITS'((int'(DOT_LEN_RESET) * int'(RATIO_RESET)) >> 8);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KEYER_ENABLE  = 3'd0,
      CSR_IAMBIC_ENABLE = 3'd1,
      CSR_WPM           = 3'd2,
      CSR_DASH_RATIO    = 3'd3,
      CSR_EDGE_STEP     = 3'd4,
      CSR_START_DELAY   = 3'd5
   } csr_index_type;

   // Keyer sequencer phase.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DOT   = 2'd1,
      PH_DASH  = 2'd2,
      PH_SPACE = 2'd3
   } phase_type;

   // What the envelope does on one sample.
   typedef enum logic [1:0] {
      ENV_HOLD = 2'd0,
      ENV_RISE = 2'd1,
      ENV_FALL = 2'd2
   } env_op_type;

   // Input beat.
   typedef struct packed {
      logic                dot_paddle;
      logic                dash_paddle;
      logic                serial_key;
      logic                ptt_hard;
      logic                ms_tick;
      logic                tx_start;
      logic [AMP_BITS-1:0] power_level;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [AMP_BITS-1:0] amplitude;
      logic                timeout_reload;
      logic [1:0]          keyer_phase;
   } rsp_type;

   // Registers the sequencer core reads directly.
   typedef struct packed {
      logic                  keyer_enable;
      logic                  iambic_enable;
      logic [STEP_BITS-1:0]  edge_step_q16;
      logic [DELAY_BITS-1:0] start_delay_ms;
   } cfg_type;

   // Symbol lengths in milliseconds.
   typedef struct packed {
      logic [DOT_BITS-1:0] dot_len;
      logic [LEN_BITS-1:0] dash_len;
   } lens_type;

endpackage

[src/icwk_env_step.sv]
// Envelope ramp: one rise or fall step of power times edge step, clamped, or a hold.
module icwk_env_step (
   input  logic [icwk_pkg::AMP_BITS-1:0]  envelope,
   input  logic [icwk_pkg::AMP_BITS-1:0]  power_level,
   input  logic [icwk_pkg::STEP_BITS-1:0] edge_step_q16,
   input  icwk_pkg::env_op_type           op,
   output logic [icwk_pkg::AMP_BITS-1:0]  envelope_next
);

   logic [icwk_pkg::AMP_BITS+icwk_pkg::STEP_BITS-1:0] step_prod;
   logic [icwk_pkg::AMP_BITS-1:0]                     step;
   logic [icwk_pkg::AMP_BITS:0]                       rise_sum;
   logic [icwk_pkg::AMP_BITS-1:0]                     rise_val;
   logic [icwk_pkg::AMP_BITS-1:0]                     fall_val;

   // Step size is the Q0.16 fraction of the power level, truncated.
   assign step_prod = power_level * edge_step_q16;
   assign step      = step_prod[icwk_pkg::AMP_BITS+icwk_pkg::STEP_BITS-1:icwk_pkg::STEP_BITS];

   // Rise only while below power, then clamp to power.
   always_comb begin
      if (envelope < power_level) begin
         rise_sum = {1'b0, envelope} + {1'b0, step};
      end else begin
         rise_sum = {1'b0, envelope};
      end
      if (rise_sum > {1'b0, power_level}) begin
         rise_val = power_level;
      end else begin
         rise_val = rise_sum[icwk_pkg::AMP_BITS-1:0];
      end
   end

   // Fall toward zero without wrapping.
   assign fall_val = (step >= envelope) ? '0 : (envelope - step);

   always_comb begin
      case (op)
         icwk_pkg::ENV_RISE: envelope_next = rise_val;
         icwk_pkg::ENV_FALL: envelope_next = fall_val;
         default:            envelope_next = envelope;
      endcase
   end

endmodule

[src/icwk_timing.sv]
// Symbol length registers: dot length from the speed, dash length from the ratio.
module icwk_timing (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wpm_write,
   input  logic [icwk_pkg::WPM_BITS-1:0]   wpm_data,
   input  logic [icwk_pkg::RATIO_BITS-1:0] dash_ratio_q8,
   output icwk_pkg::lens_type              lens
);

   localparam int WpmCount = 1 << icwk_pkg::WPM_BITS;

   logic [icwk_pkg::DOT_BITS-1:0]                       dot_table [WpmCount];
   logic [icwk_pkg::DOT_BITS-1:0]                       dot_len_ff;
   logic [icwk_pkg::DOT_BITS-1:0]                       dot_len_in;
   logic [icwk_pkg::LEN_BITS-1:0]                       dash_len_ff;
   logic [icwk_pkg::LEN_BITS-1:0]                       dash_len_in;
   logic [icwk_pkg::DOT_BITS+icwk_pkg::RATIO_BITS-1:0]  dash_prod;

   // Constant table of 1200 / wpm; a speed of zero counts as one.
   for (genvar i = 0; i < WpmCount; i++) begin : g_dot
      localparam int DotLen = icwk_pkg::DOT_MS_NUMERATOR / ((i == 0) ? 1 : i);
      assign dot_table[i] = icwk_pkg::DOT_BITS'(DotLen);
   end

   // Dot length is loaded together with the speed write.
   assign dot_len_in = wpm_write ? dot_table[wpm_data] : dot_len_ff;

   // Dash length is loaded at the same edge from the next dot length and the
   // next ratio, product truncated by eight bits.
   assign dash_prod   = dot_len_in * dash_ratio_q8;
   assign dash_len_in = dash_prod[icwk_pkg::DOT_BITS+icwk_pkg::RATIO_BITS-1:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_len_ff  <= icwk_pkg::DOT_LEN_RESET;
         dash_len_ff <= icwk_pkg::DASH_LEN_RESET;
      end else begin
         dot_len_ff  <= dot_len_in;
         dash_len_ff <= dash_len_in;
      end
   end

   assign lens.dot_len  = dot_len_ff;
   assign lens.dash_len = dash_len_ff;

endmodule

[src/icwk_core.sv]
// Keyer sequencer core: time keeping, start delay, dot/dash/space sequencing.
`include "assert_macros.svh"

module icwk_core #(
   parameter int TIME_BITS = icwk_pkg::TIME_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  icwk_pkg::req_type  item,
   input  icwk_pkg::cfg_type  cfg,
   input  icwk_pkg::lens_type lens,
   output icwk_pkg::rsp_type  result
);

   localparam int CmpBits = (TIME_BITS > icwk_pkg::LEN_BITS) ? TIME_BITS : icwk_pkg::LEN_BITS;
   localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

   icwk_pkg::phase_type             phase_ff, phase_in;
   logic [icwk_pkg::AMP_BITS-1:0]   envelope_ff, envelope_in, envelope_step;
   logic [TIME_BITS-1:0]            sym_ms_ff, sym_ms_in;
   logic [TIME_BITS-1:0]            delay_ms_ff, delay_ms_in;
   logic                            first_dash_ff, first_dash_in;
   logic                            last_dash_ff, last_dash_in;
   logic                            seq_active_ff, seq_active_in;
   icwk_pkg::env_op_type            env_op;
   logic                            reload;
   logic                            muted;
   logic [CmpBits-1:0]              dot_cmp, dash_cmp;

   assign dot_cmp  = CmpBits'(lens.dot_len);
   assign dash_cmp = CmpBits'(lens.dash_len);

   icwk_env_step u_env_step (
      .envelope      (envelope_ff),
      .power_level   (item.power_level),
      .edge_step_q16 (cfg.edge_step_q16),
      .op            (env_op),
      .envelope_next (envelope_step)
   );

   // Next state of the sequencer for the sample in the input register.
   always_comb begin
      logic done;
      logic dot;
      logic dash;
      logic both;
      done          = 1'b0;
      dot           = item.dot_paddle;
      dash          = item.dash_paddle;
      both          = dot && dash;
      phase_in      = phase_ff;
      sym_ms_in     = sym_ms_ff;
      delay_ms_in   = delay_ms_ff;
      first_dash_in = first_dash_ff;
      last_dash_in  = last_dash_ff;
      seq_active_in = seq_active_ff;
      env_op        = icwk_pkg::ENV_HOLD;
      reload        = 1'b0;
      muted         = 1'b0;

      // Millisecond counters saturate; a transmit start restarts the delay.
      if (item.ms_tick) begin
         if (sym_ms_in != TimeMax) begin
            sym_ms_in = sym_ms_in + 1'b1;
         end
         if (delay_ms_in != TimeMax) begin
            delay_ms_in = delay_ms_in + 1'b1;
         end
      end
      if (item.tx_start) begin
         delay_ms_in = '0;
      end

      if (delay_ms_in < TIME_BITS'(cfg.start_delay_ms)) begin
         // Silent during the start delay.
         muted = 1'b1;
      end else if (!cfg.keyer_enable) begin
         // Straight keying from any key.
         if (item.serial_key || item.ptt_hard || dot || dash) begin
            env_op = icwk_pkg::ENV_RISE;
         end else begin
            env_op = icwk_pkg::ENV_FALL;
         end
      end else if (item.serial_key) begin
         env_op = icwk_pkg::ENV_RISE;
      end else begin
         // Paddle memory for iambic alternation.
         if (dot && !dash) begin
            first_dash_in = 1'b0;
         end
         if (!dot && dash) begin
            first_dash_in = 1'b1;
         end
         if (both) begin
            seq_active_in = 1'b1;
         end

         // Dot symbol.
         if (phase_in == icwk_pkg::PH_IDLE && dot) begin
            sym_ms_in = '0;
            phase_in  = icwk_pkg::PH_DOT;
         end
         if (phase_in == icwk_pkg::PH_DOT && CmpBits'(sym_ms_in) < dot_cmp) begin
            reload = 1'b1;
            env_op = icwk_pkg::ENV_RISE;
            done   = 1'b1;
         end
         if (!done && phase_in == icwk_pkg::PH_DOT && CmpBits'(sym_ms_in) > dot_cmp) begin
            last_dash_in = 1'b0;
            sym_ms_in    = '0;
            phase_in     = icwk_pkg::PH_SPACE;
         end

         // Dash symbol.
         if (!done && phase_in == icwk_pkg::PH_IDLE && dash) begin
            sym_ms_in = '0;
            phase_in  = icwk_pkg::PH_DASH;
         end
         if (!done && phase_in == icwk_pkg::PH_DASH && CmpBits'(sym_ms_in) < dash_cmp) begin
            reload = 1'b1;
            env_op = icwk_pkg::ENV_RISE;
            done   = 1'b1;
         end
         if (!done && phase_in == icwk_pkg::PH_DASH && CmpBits'(sym_ms_in) > dash_cmp) begin
            last_dash_in = 1'b1;
            sym_ms_in    = '0;
            phase_in     = icwk_pkg::PH_SPACE;
         end

         // Inter-element space, one dot long.
         if (!done && phase_in == icwk_pkg::PH_SPACE && CmpBits'(sym_ms_in) < dot_cmp) begin
            reload = 1'b1;
            env_op = icwk_pkg::ENV_FALL;
            done   = 1'b1;
         end
         if (!done && phase_in == icwk_pkg::PH_SPACE && CmpBits'(sym_ms_in) > dot_cmp) begin
            if (!cfg.iambic_enable || !seq_active_in) begin
               phase_in = icwk_pkg::PH_IDLE;
            end else begin
               sym_ms_in = '0;
               if (!last_dash_in) begin
                  phase_in = icwk_pkg::PH_DASH;
                  if (first_dash_in && !both) begin
                     seq_active_in = 1'b0;
                     phase_in      = icwk_pkg::PH_IDLE;
                  end
               end else begin
                  phase_in = icwk_pkg::PH_DOT;
                  if (!first_dash_in && !both) begin
                     seq_active_in = 1'b0;
                     phase_in      = icwk_pkg::PH_IDLE;
                  end
               end
            end
         end

         // Anything not still running ramps down.
         if (!done) begin
            env_op = icwk_pkg::ENV_FALL;
         end
      end
   end

   assign envelope_in = envelope_step;

   // State registers advance once per processed sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= icwk_pkg::PH_IDLE;
         envelope_ff   <= '0;
         sym_ms_ff     <= '0;
         delay_ms_ff   <= TimeMax;
         first_dash_ff <= 1'b0;
         last_dash_ff  <= 1'b0;
         seq_active_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         envelope_ff   <= envelope_in;
         sym_ms_ff     <= sym_ms_in;
         delay_ms_ff   <= delay_ms_in;
         first_dash_ff <= first_dash_in;
         last_dash_ff  <= last_dash_in;
         seq_active_ff <= seq_active_in;
      end
   end

   assign result.amplitude      = muted ? '0 : envelope_step;
   assign result.timeout_reload = reload;
   assign result.keyer_phase    = phase_in;

   // A reload is only asked for while a symbol or space is running.
   `ICWK_ASSERT_NOW(a_reload_phase, reload, phase_in != icwk_pkg::PH_IDLE, "reload while idle")
   // Straight keying leaves the sequencer untouched.
   `ICWK_ASSERT_NEXT(a_straight_hold, step_en && !cfg.keyer_enable, $stable(phase_ff), "phase moved in straight keying")
   // A transmit start always restarts the delay count.
   `ICWK_ASSERT_NEXT(a_start_clear, step_en && item.tx_start, delay_ms_ff == '0, "delay not restarted")

endmodule

[src/iambic_cw_keyer_envelope.sv]
// Top level of the iambic CW keyer envelope: registers, handshakes and core.
//
// One input beat is one audio sample call and gives exactly one result beat.
// The block takes a new sample in every clock cycle unless the input side
// stalls; a sample passes an input register and then a result register, from
// which its result is offered, and a stalled result holds both registers in
// place. The whole sequencer update and the envelope step (one 16 x 16
// multiply, an add and a clamp) are done combinationally between those two
// registers. Configuration writes, including the dot and dash lengths derived
// from speed and ratio, take effect for the next sample processed. Counters
// are TIME_BITS wide and saturate.
`include "assert_macros.svh"

module iambic_cw_keyer_envelope #(
   parameter int TIME_BITS = icwk_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  icwk_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output icwk_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [icwk_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [icwk_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                              in_valid_ff, in_valid_in;
   icwk_pkg::req_type                 in_item_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   icwk_pkg::rsp_type                 rsp_data_ff;
   icwk_pkg::rsp_type                 core_result;
   logic                              out_free;
   logic                              advance;
   logic                              accept;
   logic                              wpm_write;
   icwk_pkg::cfg_type                 cfg_ff, cfg_in;
   logic [icwk_pkg::RATIO_BITS-1:0]   ratio_ff, ratio_in;
   icwk_pkg::lens_type                lens;
   icwk_pkg::csr_index_type           csr_sel;

   // Configuration register writes.
   assign csr_sel = icwk_pkg::csr_index_type'(csr_index);

   always_comb begin
      cfg_in    = cfg_ff;
      ratio_in  = ratio_ff;
      wpm_write = 1'b0;
      if (csr_we) begin
         case (csr_sel)
            icwk_pkg::CSR_KEYER_ENABLE:  cfg_in.keyer_enable = csr_wdata[0];
            icwk_pkg::CSR_IAMBIC_ENABLE: cfg_in.iambic_enable = csr_wdata[0];
            icwk_pkg::CSR_WPM:           wpm_write = 1'b1;
            icwk_pkg::CSR_DASH_RATIO:    ratio_in = csr_wdata[icwk_pkg::RATIO_BITS-1:0];
            icwk_pkg::CSR_EDGE_STEP:     cfg_in.edge_step_q16 = csr_wdata[icwk_pkg::STEP_BITS-1:0];
            icwk_pkg::CSR_START_DELAY:   cfg_in.start_delay_ms = csr_wdata[icwk_pkg::DELAY_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keyer_enable   <= icwk_pkg::KEYER_ENABLE_RESET;
         cfg_ff.iambic_enable  <= icwk_pkg::IAMBIC_ENABLE_RESET;
         cfg_ff.edge_step_q16  <= icwk_pkg::EDGE_STEP_RESET;
         cfg_ff.start_delay_ms <= icwk_pkg::START_DELAY_RESET;
         ratio_ff              <= icwk_pkg::RATIO_RESET;
      end else begin
         cfg_ff   <= cfg_in;
         ratio_ff <= ratio_in;
      end
   end

   icwk_timing u_timing (
      .clock         (clock),
      .reset         (reset),
      .wpm_write     (wpm_write),
      .wpm_data      (csr_wdata[icwk_pkg::WPM_BITS-1:0]),
      .dash_ratio_q8 (ratio_in),
      .lens          (lens)
   );

   // Handshake: the input register moves on whenever the result slot is free.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   icwk_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .lens    (lens),
      .result  (core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The input side only stalls with a sample held and the result slot blocked.
   `ICWK_ASSERT_NOW(a_stall_cause, req_stall, in_valid_ff && rsp_valid_ff && rsp_stall, "stall without cause")
   // A processed sample always lands in the result register.
   `ICWK_ASSERT_NEXT(a_advance_result, advance, rsp_valid_ff, "result lost")

endmodule
